FILE: rtl/core/sph_pkg.sv
// ----------------------------------------------------------------------------
// sph_pkg
// Shared types and constants of the space packet header parser.
// ----------------------------------------------------------------------------
package sph_pkg;

  localparam int NUM_TYPES    = 4;
  localparam int TYPE_W       = $clog2(NUM_TYPES);
  localparam int HEADER_BYTES = 12;
  localparam int POS_W        = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [10:0] APID_MASK         = 11'h7FF;
  localparam logic [13:0] SEQ_MASK          = 14'h3FFF;
  localparam logic [10:0] APID_EVENT_RST    = 11'h5A2;
  localparam logic [10:0] APID_SPECTRUM_RST = 11'h5A0;
  localparam logic [10:0] APID_TIMESER_RST  = 11'h5A1;
  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd4096;
  localparam logic [15:0] LENGTH_OFFSET     = 16'd5;

  typedef enum logic [TYPE_W-1:0] {
    PT_EVENT      = 2'd0,
    PT_SPECTRUM   = 2'd1,
    PT_TIMESERIES = 2'd2,
    PT_UNKNOWN    = 2'd3
  } ptype_e;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_WORD   = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_APID_EVENT      = 2'd0,
    CFG_APID_SPECTRUM   = 2'd1,
    CFG_APID_TIMESERIES = 2'd2,
    CFG_MAX_PAYLOAD     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] apid_event;
    logic [10:0] apid_spectrum;
    logic [10:0] apid_timeseries;
    logic [15:0] max_payload_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       packet_start;
  } in_beat_t;

  typedef struct packed {
    kind_e       item_kind;
    ptype_e      packet_type;
    logic [10:0] apid_value;
    logic [13:0] sequence_value;
    logic        sequence_gap;
    logic [31:0] coarse_time;
    logic [15:0] fine_time;
    logic [15:0] payload_bytes;
    logic        length_error;
    logic [31:0] type_packet_count;
    logic [31:0] data_word;
    logic        last_item;
  } out_beat_t;

  // work handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    ptype_e      ptype;
    logic [10:0] apid;
    logic [13:0] seq;
    logic [31:0] coarse;
    logic [15:0] fine;
    logic [15:0] pay;
    logic        lerr;
    logic [31:0] word;
    logic        last;
  } cmd_t;

endpackage

FILE: rtl/core/sph_front.sv
// ----------------------------------------------------------------------------
// sph_front
// Byte tracker: header capture, classification and payload word assembly.
// ----------------------------------------------------------------------------
module sph_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sph_pkg::in_beat_t beat_i,
  input  sph_pkg::cfg_t     cfg_i,
  output logic              push_o,
  output sph_pkg::cmd_t     cmd_o
);

  logic [sph_pkg::POS_W-1:0] pos_q, pos_d;
  logic [55:0]               shift_q, shift_d;
  logic [10:0]               apid_q, apid_d;
  logic [13:0]               seq_q, seq_d;
  logic                      in_pay_q, in_pay_d;
  sph_pkg::ptype_e           type_q, type_d;
  logic [15:0]               words_q, words_d;
  logic [31:0]               asm_q, asm_d;
  logic [1:0]                biw_q, biw_d;

  logic [63:0]               shift_n;
  logic [sph_pkg::POS_W-1:0] pos_n;
  logic [15:0]               pay;
  logic [15:0]               nwords;
  logic                      lerr;
  sph_pkg::ptype_e           ptype;
  logic [31:0]               asm_n;
  logic [2:0]                biw_n;
  logic [2:0]                need;
  logic [15:0]               rem;

  assign shift_n = {shift_q, beat_i.stream_byte};
  assign pos_n   = pos_q + 1'b1;
  assign pay     = shift_n[63:48] - sph_pkg::LENGTH_OFFSET;
  assign lerr    = pay > cfg_i.max_payload_bytes;
  assign rem     = words_q - 16'd1;
  assign biw_n   = {1'b0, biw_q} + 3'd1;
  assign need    = (type_q == sph_pkg::PT_EVENT) ? 3'd4 : 3'd2;

  // event type wins over spectrum, spectrum over time-series
  always_comb begin
    if (apid_q == cfg_i.apid_event) begin
      ptype = sph_pkg::PT_EVENT;
    end else if (apid_q == cfg_i.apid_spectrum) begin
      ptype = sph_pkg::PT_SPECTRUM;
    end else if (apid_q == cfg_i.apid_timeseries) begin
      ptype = sph_pkg::PT_TIMESERIES;
    end else begin
      ptype = sph_pkg::PT_UNKNOWN;
    end
  end

  assign nwords = (ptype == sph_pkg::PT_EVENT) ? {2'b00, pay[15:2]} : {1'b0, pay[15:1]};

  always_comb begin
    if (type_q == sph_pkg::PT_EVENT) begin
      asm_n = {asm_q[23:0], beat_i.stream_byte};
    end else if (biw_q == 2'd0) begin
      asm_n = {24'd0, beat_i.stream_byte};
    end else begin
      asm_n = asm_q | {16'd0, beat_i.stream_byte, 8'd0};
    end
  end

  always_comb begin
    pos_d    = pos_q;
    shift_d  = shift_q;
    apid_d   = apid_q;
    seq_d    = seq_q;
    in_pay_d = in_pay_q;
    type_d   = type_q;
    words_d  = words_q;
    asm_d    = asm_q;
    biw_d    = biw_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    if (accept_i) begin
      if (beat_i.packet_start) begin
        shift_d  = {48'd0, beat_i.stream_byte};
        pos_d    = sph_pkg::POS_W'(1);
        in_pay_d = 1'b0;
      end else if (pos_q != '0) begin
        shift_d = shift_n[55:0];
        pos_d   = pos_n;
        if (pos_n == sph_pkg::POS_W'(2)) begin
          apid_d = shift_n[10:0] & sph_pkg::APID_MASK;
        end
        if (pos_n == sph_pkg::POS_W'(4)) begin
          seq_d = shift_n[13:0] & sph_pkg::SEQ_MASK;
        end
        if (pos_n == sph_pkg::POS_W'(sph_pkg::HEADER_BYTES)) begin
          pos_d        = '0;
          type_d       = ptype;
          asm_d        = '0;
          biw_d        = '0;
          in_pay_d     = !lerr && (nwords != 16'd0);
          words_d      = in_pay_d ? nwords : 16'd0;
          push_o       = 1'b1;
          cmd_o.kind   = sph_pkg::KIND_HEADER;
          cmd_o.ptype  = ptype;
          cmd_o.apid   = apid_q;
          cmd_o.seq    = seq_q;
          cmd_o.coarse = shift_n[47:16];
          cmd_o.fine   = shift_n[15:0];
          cmd_o.pay    = pay;
          cmd_o.lerr   = lerr;
          cmd_o.last   = !in_pay_d;
        end
      end else if (in_pay_q) begin
        asm_d = asm_n;
        biw_d = biw_n[1:0];
        if (biw_n >= need) begin
          asm_d       = '0;
          biw_d       = '0;
          words_d     = rem;
          in_pay_d    = (rem != 16'd0);
          push_o      = 1'b1;
          cmd_o.kind  = sph_pkg::KIND_WORD;
          cmd_o.ptype = type_q;
          cmd_o.word  = asm_n;
          cmd_o.last  = (rem == 16'd0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      shift_q  <= '0;
      apid_q   <= '0;
      seq_q    <= '0;
      in_pay_q <= 1'b0;
      type_q   <= sph_pkg::PT_EVENT;
      words_q  <= '0;
      asm_q    <= '0;
      biw_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      apid_q   <= apid_d;
      seq_q    <= seq_d;
      in_pay_q <= in_pay_d;
      type_q   <= type_d;
      words_q  <= words_d;
      asm_q    <= asm_d;
      biw_q    <= biw_d;
    end
  end

endmodule

FILE: rtl/core/sph_queue.sv
// ----------------------------------------------------------------------------
// sph_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module sph_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sph_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sph_pkg::cmd_t cmd_o
);

  sph_pkg::cmd_t              mem_q [sph_pkg::QUEUE_DEPTH];
  logic [sph_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [sph_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == sph_pkg::QCNT_W'(sph_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  function automatic logic [sph_pkg::QPTR_W-1:0] ptr_inc(logic [sph_pkg::QPTR_W-1:0] p);
    logic [sph_pkg::QPTR_W-1:0] r;
    if (p == sph_pkg::QPTR_W'(sph_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + sph_pkg::QCNT_W'(push_i) - sph_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/core/sph_back.sv
// ----------------------------------------------------------------------------
// sph_back
// Per-type counters and sequence check, result register.
// ----------------------------------------------------------------------------
module sph_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  sph_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sph_pkg::out_beat_t out_data_o
);

  logic [31:0]        cnt_q [sph_pkg::NUM_TYPES];
  logic [13:0]        lseq_q [sph_pkg::NUM_TYPES];
  logic [sph_pkg::NUM_TYPES-1:0] sval_q;
  logic               out_valid_q, out_valid_d;
  sph_pkg::out_beat_t out_q, out_d;

  logic [31:0] cnt_n;
  logic        gap;
  logic        is_hdr;

  assign pop_o  = valid_i && (!out_valid_q || out_ready_i);
  assign is_hdr = (cmd_i.kind == sph_pkg::KIND_HEADER);
  assign cnt_n  = cnt_q[cmd_i.ptype] + 32'd1;
  // 16383 followed by 0 is no gap
  assign gap    = sval_q[cmd_i.ptype] &&
                  (((lseq_q[cmd_i.ptype] + 14'd1) & sph_pkg::SEQ_MASK) != cmd_i.seq);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      out_valid_d             = 1'b1;
      out_d                   = '0;
      out_d.item_kind         = cmd_i.kind;
      out_d.packet_type       = cmd_i.ptype;
      out_d.last_item         = cmd_i.last;
      if (is_hdr) begin
        out_d.apid_value        = cmd_i.apid;
        out_d.sequence_value    = cmd_i.seq;
        out_d.sequence_gap      = gap;
        out_d.coarse_time       = cmd_i.coarse;
        out_d.fine_time         = cmd_i.fine;
        out_d.payload_bytes     = cmd_i.pay;
        out_d.length_error      = cmd_i.lerr;
        out_d.type_packet_count = cnt_n;
      end else begin
        out_d.data_word = cmd_i.word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sval_q      <= '0;
      for (int t = 0; t < sph_pkg::NUM_TYPES; t++) begin
        cnt_q[t]  <= '0;
        lseq_q[t] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o && is_hdr) begin
        cnt_q[cmd_i.ptype]  <= cnt_n;
        lseq_q[cmd_i.ptype] <= cmd_i.seq;
        sval_q[cmd_i.ptype] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/space_packet_header_parser.sv
// ----------------------------------------------------------------------------
// space_packet_header_parser
// Parses packet headers from a byte stream and emits summaries and payload words.
// ----------------------------------------------------------------------------
// throughput: one byte beat per cycle, set by the front, stalled when queue is full
// a result passes the command queue, then the result register, on its way out
// the two-entry command queue and the result register absorb output stalls
// reset: asynchronous, clears control and counters, config to defaults, no sweep
module space_packet_header_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sph_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sph_pkg::out_beat_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [sph_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sph_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  sph_pkg::cfg_t cfg_q;
  sph_pkg::cmd_t f_cmd, q_cmd;
  logic          f_push, q_full, q_valid, q_pop;
  logic          accept;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.apid_event        <= sph_pkg::APID_EVENT_RST;
      cfg_q.apid_spectrum     <= sph_pkg::APID_SPECTRUM_RST;
      cfg_q.apid_timeseries   <= sph_pkg::APID_TIMESER_RST;
      cfg_q.max_payload_bytes <= sph_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      case (sph_pkg::cfg_idx_e'(cfg_idx_i))
        sph_pkg::CFG_APID_EVENT:      cfg_q.apid_event      <= cfg_data_i[10:0];
        sph_pkg::CFG_APID_SPECTRUM:   cfg_q.apid_spectrum   <= cfg_data_i[10:0];
        sph_pkg::CFG_APID_TIMESERIES: cfg_q.apid_timeseries <= cfg_data_i[10:0];
        sph_pkg::CFG_MAX_PAYLOAD:     cfg_q.max_payload_bytes <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sph_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_data_i),
    .cfg_i    (cfg_q),
    .push_o   (f_push),
    .cmd_o    (f_cmd)
  );

  sph_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  sph_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
